/* src/irfs_pkg.sv */
// ----------------------------------------------------------------------------
// irfs_pkg: shared types and constants of the input recording frame store
// Operation, status and mode codes, payload structs and the default sizes.
// ----------------------------------------------------------------------------
package irfs_pkg;

  localparam int unsigned DefStoreDepth = 65536;
  localparam logic [15:0] RepeatMark    = 16'hFFFF;
  localparam logic [15:0] DefMaxInstr   = 16'd20000;
  localparam logic [15:0] MaxFrameIn    = 16'hFFFE;

  typedef enum logic [3:0] {
    OP_PURGE     = 4'd0,
    OP_LOAD      = 4'd1,
    OP_SCAN      = 4'd2,
    OP_REWIND    = 4'd3,
    OP_GET       = 4'd4,
    OP_NEXT      = 4'd5,
    OP_START     = 4'd6,
    OP_STORE     = 4'd7,
    OP_END_FRAME = 4'd8,
    OP_START_REC = 4'd9,
    OP_AMEND     = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_END  = 3'd1,
    ST_MODE = 3'd2,
    ST_FULL = 3'd3,
    ST_CUT  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_END  = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_REC  = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_EXEC,
    S_REW,
    S_SCAN,
    S_CP_RD,
    S_CP_WR,
    S_FIN
  } state_e;

  typedef enum logic [3:0] {
    PH_FIN,
    PH_REW,
    PH_SCAN_FIX,
    PH_SCAN_GO,
    PH_SCAN_HDR,
    PH_GB,
    PH_NX1,
    PH_NX2,
    PH_REC_LEN,
    PH_AM1,
    PH_AM2
  } phase_e;

  typedef struct packed {
    logic [3:0]  operation;
    logic [7:0]  data_byte;
    logic [15:0] instr_count;
    logic [31:0] start_cycles;
  } irfs_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_byte;
    logic [15:0] frame_instructions;
    logic [1:0]  mode;
    logic [14:0] frames_total;
    logic [14:0] frame_index;
    logic [31:0] first_cycles;
  } irfs_out_t;

endpackage

/* src/input_recording_frame_store.sv */
// ----------------------------------------------------------------------------
// input_recording_frame_store: byte store of input-replay frames
// Load, scan, play back, record and amend replay frames in one byte memory.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in       | input     | in_valid_i/in_stall_o | in_data_i   (irfs_in_t)
//  out      | output    | out_valid_o/out_stall_i| out_data_o (irfs_out_t)
//  cfg      | input     | cfg_we_i             | cfg_wdata_i (max instructions)
//
//  Scan reads each frame header in turn, and start recording of a repeated
//  frame copies its bytes one at a time, a read then a write; all memory
//  traffic shares one byte port.
//  One transaction is worked on at a time; in_stall_o is high while busy.
//  A finished result waits in the output register; the next transaction is
//  taken meanwhile and its result waits until that register is free.
//  Reset clears all control state; memory contents are undefined until written.
module input_recording_frame_store #(
  parameter int unsigned STORE_DEPTH = irfs_pkg::DefStoreDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  irfs_pkg::irfs_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output irfs_pkg::irfs_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);
  import irfs_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = $clog2(STORE_DEPTH + 32'd131072) + 1;
  localparam logic [PW-1:0] Depth = PW'(STORE_DEPTH);
  localparam logic [PW-1:0] Two   = PW'(2);
  localparam logic [PW-1:0] Four  = PW'(4);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_q;

  state_e state_q, state_d, nxt;
  phase_e ph_q, ph_d;
  mode_e  mode_q, mode_d;
  status_e st_q, st_d;

  logic [PW-1:0] used_q, used_d, hdr_q, hdr_d, prev_q, prev_d, inp_q, inp_d;
  logic [PW-1:0] dend_q, dend_d, ftot_q, ftot_d, fnow_q, fnow_d;
  logic [PW-1:0] ra_q, ra_d, wa_q, wa_d, tot_q, tot_d, cnt_q, cnt_d;
  logic [31:0]   cyc_q, cyc_d, rbuf_q, rbuf_d, wbuf_q, wbuf_d;
  logic [15:0]   maxi_q, icnt_q, icnt_d, fic_q, fic_d;
  logic [7:0]    rb_q, rb_d, rd_byte;
  logic [2:0]    rn_q, rn_d, wn_q, wn_d;
  logic          pend_q, pend_d, oob_q, oob_d, scan_q, scan_d;
  logic          ovld_q;
  irfs_out_t     out_q;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  logic          accept, fin_go, do_ef;
  logic [PW-1:0] t_a, t_b;
  logic [16:0]   sum;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign fin_go      = (state_q == S_FIN) && (!ovld_q || !out_stall_i);
  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;
  assign rd_byte     = oob_q ? 8'd0 : rdata_q;

  // single byte port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = nxt;
      S_RD:    if (rn_q == 3'd0 && pend_q) state_d = S_EXEC;
      S_WR:    if (wn_q == 3'd1) state_d = S_EXEC;
      S_EXEC, S_REW, S_SCAN, S_CP_RD: state_d = nxt;
      S_CP_WR: state_d = S_CP_RD;
      S_FIN:   if (!ovld_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    nxt = S_FIN;
    ph_d = ph_q; mode_d = mode_q; st_d = st_q;
    used_d = used_q; hdr_d = hdr_q; prev_d = prev_q; inp_d = inp_q;
    dend_d = dend_q; ftot_d = ftot_q; fnow_d = fnow_q; cyc_d = cyc_q;
    ra_d = ra_q; wa_d = wa_q; tot_d = tot_q; cnt_d = cnt_q;
    rbuf_d = rbuf_q; wbuf_d = wbuf_q; icnt_d = icnt_q; fic_d = fic_q;
    rb_d = rb_q; rn_d = rn_q; wn_d = wn_q; pend_d = 1'b0; oob_d = oob_q;
    scan_d = scan_q; do_ef = 1'b0;
    mem_we = 1'b0; mem_addr = ra_q[AW-1:0]; mem_wdata = wbuf_q[7:0];
    t_a = '0; t_b = '0; sum = '0;

    unique case (state_q)
      S_IDLE: if (accept) begin
        icnt_d = in_data_i.instr_count;
        st_d = ST_OK; rb_d = '0; fic_d = '0;
        case (op_e'(in_data_i.operation))
          OP_PURGE: begin
            used_d = '0; hdr_d = '0; prev_d = '0; inp_d = '0; dend_d = '0;
            ftot_d = '0; fnow_d = '0; cyc_d = '0; mode_d = MODE_END;
          end
          OP_LOAD: begin
            if (mode_q == MODE_REC) st_d = ST_MODE;
            else if (used_q >= Depth) st_d = ST_FULL;
            else begin
              mem_we = 1'b1; mem_addr = used_q[AW-1:0];
              mem_wdata = in_data_i.data_byte;
              used_d = used_q + 1'b1;
            end
          end
          OP_SCAN: begin
            if (mode_q == MODE_REC) st_d = ST_MODE;
            else begin
              scan_d = 1'b1; tot_d = used_q;
              if (used_q >= Four) begin
                ra_d = Two; rn_d = 3'd2; ph_d = PH_SCAN_FIX; nxt = S_RD;
              end else nxt = S_SCAN;
            end
          end
          OP_REWIND: begin
            scan_d = 1'b0; nxt = S_REW;
          end
          OP_GET: begin
            if (mode_q != MODE_PLAY) st_d = ST_MODE;
            else if (inp_q < dend_q) begin
              ra_d = inp_q; rn_d = 3'd1; ph_d = PH_GB; nxt = S_RD;
            end else st_d = ST_END;
          end
          OP_NEXT: begin
            if (mode_q != MODE_PLAY) st_d = ST_MODE;
            else if (fnow_q + 1'b1 >= ftot_q) st_d = ST_END;
            else begin
              fnow_d = fnow_q + 1'b1;
              ra_d = hdr_q + Two; rn_d = 3'd2; ph_d = PH_NX1; nxt = S_RD;
            end
          end
          OP_START: begin
            if (mode_q != MODE_END) st_d = ST_MODE;
            else if (used_q + Four > Depth) st_d = ST_FULL;
            else begin
              hdr_d = used_q; fnow_d = ftot_q; inp_d = used_q + Four;
              if (used_q == '0) cyc_d = in_data_i.start_cycles;
              mode_d = MODE_REC;
            end
          end
          OP_STORE: begin
            t_a = inp_q - (hdr_q + Four);
            if (mode_q != MODE_REC) st_d = ST_MODE;
            else if (inp_q >= Depth || t_a >= PW'(MaxFrameIn)) st_d = ST_FULL;
            else begin
              mem_we = 1'b1; mem_addr = inp_q[AW-1:0];
              mem_wdata = in_data_i.data_byte;
              inp_d = inp_q + 1'b1;
            end
          end
          OP_END_FRAME: begin
            if (mode_q != MODE_REC) st_d = ST_MODE;
            else do_ef = 1'b1;
          end
          OP_START_REC: begin
            t_a = inp_q - prev_q;
            if (mode_q != MODE_PLAY) st_d = ST_MODE;
            else if (hdr_q + Four > Depth) st_d = ST_FULL;
            else if (prev_q == '0) begin
              dend_d = '0; used_d = hdr_q; ftot_d = fnow_q; mode_d = MODE_REC;
            end else if (dend_q <= hdr_q) begin
              if (hdr_q + Four + t_a > Depth) st_d = ST_FULL;
              else begin
                // repeated frame: copy the replayed bytes behind the header
                ra_d = prev_q; wa_d = hdr_q + Four; cnt_d = t_a; nxt = S_CP_RD;
              end
            end else begin
              ra_d = prev_q - Two; rn_d = 3'd2; ph_d = PH_REC_LEN; nxt = S_RD;
            end
          end
          OP_AMEND: begin
            if (mode_q != MODE_REC) st_d = ST_MODE;
            else if (hdr_q < Four || prev_q < Four || inp_q > hdr_q + Four) do_ef = 1'b1;
            else begin
              ra_d = prev_q - Two; rn_d = 3'd2; ph_d = PH_AM1; nxt = S_RD;
            end
          end
          default: ;
        endcase
        if (do_ef) begin
          t_a = inp_q - (hdr_q + Four);
          wbuf_d = {t_a[15:0], in_data_i.instr_count};
          wa_d = hdr_q; wn_d = 3'd4; ph_d = PH_FIN; nxt = S_WR;
          prev_d = hdr_q + Four; dend_d = inp_q; hdr_d = inp_q; used_d = inp_q;
          ftot_d = ftot_q + 1'b1; fnow_d = ftot_q + 1'b1; mode_d = MODE_END;
        end
      end
      S_RD: begin
        if (pend_q) rbuf_d = {rd_byte, rbuf_q[31:8]};
        if (rn_q != 3'd0) begin
          mem_addr = ra_q[AW-1:0];
          pend_d = 1'b1; oob_d = (ra_q >= Depth);
          ra_d = ra_q + 1'b1; rn_d = rn_q - 3'd1;
        end
      end
      S_WR: begin
        mem_we = (wa_q < Depth); mem_addr = wa_q[AW-1:0]; mem_wdata = wbuf_q[7:0];
        wbuf_d = {8'd0, wbuf_q[31:8]};
        wa_d = wa_q + 1'b1; wn_d = wn_q - 3'd1;
      end
      S_REW: begin
        fnow_d = '0; hdr_d = '0; prev_d = '0;
        if (used_q == '0) begin
          dend_d = '0; inp_d = '0; mode_d = MODE_END; fic_d = '0;
          st_d = (scan_q && used_q < tot_q) ? ST_CUT : ST_END;
        end else begin
          ra_d = '0; rn_d = 3'd4; ph_d = PH_REW; nxt = S_RD;
        end
      end
      S_SCAN: begin
        used_d = '0; fnow_d = '0; ftot_d = '0; cnt_d = '0;
        if (tot_q >= Four) begin
          ra_d = '0; rn_d = 3'd4; ph_d = PH_SCAN_HDR; nxt = S_RD;
        end else nxt = S_REW;
      end
      S_CP_RD: begin
        if (cnt_q == '0) begin
          inp_d = wa_q;
          ra_d = prev_q - Two; rn_d = 3'd2; ph_d = PH_REC_LEN; nxt = S_RD;
        end else begin
          mem_addr = ra_q[AW-1:0]; oob_d = (ra_q >= Depth); nxt = S_CP_WR;
        end
      end
      S_CP_WR: begin
        mem_we = (wa_q < Depth); mem_addr = wa_q[AW-1:0]; mem_wdata = rd_byte;
        ra_d = ra_q + 1'b1; wa_d = wa_q + 1'b1; cnt_d = cnt_q - 1'b1;
      end
      S_EXEC: begin
        case (ph_q)
          PH_REW: begin
            t_a = (rbuf_q[31:16] == RepeatMark) ? Four : Four + PW'(rbuf_q[31:16]);
            inp_d = Four; dend_d = (t_a > used_q) ? used_q : t_a;
            mode_d = MODE_PLAY; fic_d = rbuf_q[15:0];
            st_d = (scan_q && used_q < tot_q) ? ST_CUT : ST_OK;
          end
          PH_SCAN_FIX: begin
            if (rbuf_q[31:16] == RepeatMark) begin
              wa_d = Two; wbuf_d = '0; wn_d = 3'd2; ph_d = PH_SCAN_GO; nxt = S_WR;
            end else nxt = S_SCAN;
          end
          PH_SCAN_GO: nxt = S_SCAN;
          PH_SCAN_HDR: begin
            t_a = cnt_q + Four +
                  ((rbuf_q[31:16] == RepeatMark) ? '0 : PW'(rbuf_q[31:16]));
            if (t_a > tot_q || rbuf_q[15:0] > maxi_q) nxt = S_REW;
            else begin
              ftot_d = ftot_q + 1'b1; used_d = t_a; cnt_d = t_a;
              if (t_a + Four <= tot_q) begin
                ra_d = t_a; rn_d = 3'd4; nxt = S_RD;
              end else nxt = S_REW;
            end
          end
          PH_GB: begin
            rb_d = rbuf_q[31:24]; inp_d = inp_q + 1'b1;
          end
          PH_NX1: begin
            if (rbuf_q[31:16] == RepeatMark) t_b = hdr_q + Four;
            else begin
              prev_d = hdr_q + Four; t_b = dend_q;
            end
            hdr_d = t_b; ra_d = t_b; rn_d = 3'd4; ph_d = PH_NX2; nxt = S_RD;
          end
          PH_NX2: begin
            if (rbuf_q[31:16] == RepeatMark) inp_d = prev_q;
            else begin
              inp_d = hdr_q + Four;
              t_a = hdr_q + Four + PW'(rbuf_q[31:16]);
              dend_d = (t_a > used_q) ? used_q : t_a;
            end
            fic_d = rbuf_q[15:0];
          end
          PH_REC_LEN: begin
            dend_d = prev_q + PW'(rbuf_q[31:16]);
            used_d = hdr_q; ftot_d = fnow_q; mode_d = MODE_REC;
          end
          PH_AM1: begin
            // previous frame is repeated when its data does not end at our header
            t_b = (prev_q + PW'(rbuf_q[31:16]) != hdr_q) ? hdr_q - Four : prev_q - Four;
            ra_d = t_b; wa_d = t_b; rn_d = 3'd2; ph_d = PH_AM2; nxt = S_RD;
          end
          PH_AM2: begin
            sum = {1'b0, rbuf_q[31:16]} + {1'b0, icnt_q};
            wbuf_d = {16'd0, sum[16] ? RepeatMark : sum[15:0]};
            wn_d = 3'd2; mode_d = MODE_END; ph_d = PH_FIN; nxt = S_WR;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ph_q <= PH_FIN; mode_q <= MODE_END; st_q <= ST_OK;
      used_q <= '0; hdr_q <= '0; prev_q <= '0; inp_q <= '0; dend_q <= '0;
      ftot_q <= '0; fnow_q <= '0; cyc_q <= '0; maxi_q <= DefMaxInstr;
      rn_q <= '0; wn_q <= '0; pend_q <= 1'b0; scan_q <= 1'b0; ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; ph_q <= ph_d; mode_q <= mode_d; st_q <= st_d;
      used_q <= used_d; hdr_q <= hdr_d; prev_q <= prev_d; inp_q <= inp_d;
      dend_q <= dend_d; ftot_q <= ftot_d; fnow_q <= fnow_d; cyc_q <= cyc_d;
      rn_q <= rn_d; wn_q <= wn_d; pend_q <= pend_d; scan_q <= scan_d;
      if (cfg_we_i) maxi_q <= cfg_wdata_i;
      if (fin_go) ovld_q <= 1'b1;
      else if (!out_stall_i) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= ra_d; wa_q <= wa_d; tot_q <= tot_d; cnt_q <= cnt_d;
    rbuf_q <= rbuf_d; wbuf_q <= wbuf_d; icnt_q <= icnt_d; fic_q <= fic_d;
    rb_q <= rb_d; oob_q <= oob_d;
    if (fin_go) begin
      out_q.status             <= st_q;
      out_q.read_byte          <= rb_q;
      out_q.frame_instructions <= fic_q;
      out_q.mode               <= mode_q;
      out_q.frames_total       <= ftot_q[14:0];
      out_q.frame_index        <= fnow_q[14:0];
      out_q.first_cycles       <= cyc_q;
    end
  end

endmodule

/* src/irfs_checker.sv */
// ----------------------------------------------------------------------------
// irfs_checker: port-level checks of the input recording frame store
// Watches the result channel and the relations between result fields.
// ----------------------------------------------------------------------------
module irfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input irfs_pkg::irfs_out_t out_data_o
);
  import irfs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_index_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.frame_index <= out_data_o.frames_total)
    else $error("frame index beyond frame total");

  a_byte_only_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_byte != 8'd0 |->
      out_data_o.status == ST_OK && out_data_o.mode == MODE_PLAY)
    else $error("read byte outside playback");

  a_rec_no_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode == MODE_REC |->
      out_data_o.frame_instructions == 16'd0 && out_data_o.status != ST_CUT)
    else $error("recording result carries playback fields");

endmodule

bind input_recording_frame_store irfs_checker u_irfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* tb/input_recording_frame_store_tb.sv */
// ----------------------------------------------------------------------------
// input_recording_frame_store_tb: self-checking bench of the frame store
// Loads a short block at the bottom of the store first and keeps every session
// well inside it, so that no read can hit a never-written entry, then runs
// directed checks (record, playback, repeated frames, amend, wrong mode) and
// random record, playback, load and scan sessions under several idle and
// stall mixes. A local model predicts every result.
// ----------------------------------------------------------------------------
module input_recording_frame_store_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import irfs_pkg::*;

  localparam int unsigned Depth      = DefStoreDepth;
  localparam int unsigned CycLimit   = 3000000;
  localparam int unsigned IdleWait   = 40;
  localparam int unsigned PrefillLen = 128;
  localparam int unsigned PurgeAt    = 48;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  irfs_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  irfs_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  input_recording_frame_store #(.STORE_DEPTH(Depth)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [7:0]  mem [Depth];
  int unsigned used_sz, hdr_pos, prev_pos, in_pos, end_pos;
  int unsigned frm_total, frm_now, cyc_start, max_instr;
  mode_e       cur_mode;

  irfs_out_t   result_q[$];
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles = 0;

  function automatic int unsigned rd8(int unsigned p);
    return (p < Depth) ? int'(mem[p]) : 0;
  endfunction

  function automatic int unsigned rd16(int unsigned p);
    return rd8(p) | (rd8(p + 1) << 8);
  endfunction

  function automatic void wr8(int unsigned p, int unsigned v);
    if (p < Depth) mem[p] = v[7:0];
  endfunction

  function automatic void wr16(int unsigned p, int unsigned v);
    wr8(p, v & 8'hFF);
    wr8(p + 1, (v >> 8) & 8'hFF);
  endfunction

  function automatic int unsigned clamp_end(int unsigned e);
    return (e > used_sz) ? used_sz : e;
  endfunction

  function automatic void clear_model();
    used_sz = 0; hdr_pos = 0; prev_pos = 0; in_pos = 0; end_pos = 0;
    frm_total = 0; frm_now = 0; cyc_start = 0;
    cur_mode = MODE_END;
  endfunction

  function automatic status_e rewind_model(output int unsigned ic);
    int unsigned cnt;
    frm_now = 0; hdr_pos = 0; prev_pos = 0;
    if (used_sz == 0) begin
      end_pos = 0; in_pos = 0; cur_mode = MODE_END; ic = 0;
      return ST_END;
    end
    cnt = rd16(2);
    if (cnt == RepeatMark) cnt = 0;
    in_pos = 4;
    end_pos = clamp_end(4 + cnt);
    cur_mode = MODE_PLAY;
    ic = rd16(0);
    return ST_OK;
  endfunction

  function automatic bit scan_model();
    int unsigned total, i, ic, n;
    total = used_sz; i = 0;
    if (used_sz >= 4 && rd16(2) == RepeatMark) wr16(2, 0);
    used_sz = 0; frm_now = 0; frm_total = 0;
    while (i + 4 <= total) begin
      ic = rd16(i);
      n = rd16(i + 2);
      i += (n == RepeatMark) ? 4 : 4 + n;
      if (i > total) break;
      if (ic > max_instr) break;
      frm_total++;
      used_sz = i;
    end
    return used_sz < total;
  endfunction

  function automatic void close_frame(int unsigned icount);
    int unsigned cnt;
    cnt = in_pos - (hdr_pos + 4);
    wr16(hdr_pos, icount);
    wr16(hdr_pos + 2, cnt);
    prev_pos = hdr_pos + 4;
    end_pos = prev_pos + cnt;
    hdr_pos = end_pos;
    frm_total++;
    frm_now = frm_total;
    used_sz = hdr_pos;
    cur_mode = MODE_END;
  endfunction

  function automatic irfs_out_t frame_store_predict(irfs_in_t t);
    irfs_out_t   r;
    status_e     st;
    int unsigned rb, fic, cnt, n, pf, sum;
    bit          cut, rep;
    st = ST_OK; rb = 0; fic = 0;
    case (t.operation)
      OP_PURGE: clear_model();
      OP_LOAD: begin
        if (cur_mode == MODE_REC) st = ST_MODE;
        else if (used_sz >= Depth) st = ST_FULL;
        else begin
          wr8(used_sz, t.data_byte);
          used_sz++;
        end
      end
      OP_SCAN: begin
        if (cur_mode == MODE_REC) st = ST_MODE;
        else begin
          cut = scan_model();
          st = rewind_model(fic);
          if (cut) st = ST_CUT;
        end
      end
      OP_REWIND: st = rewind_model(fic);
      OP_GET: begin
        if (cur_mode != MODE_PLAY) st = ST_MODE;
        else if (in_pos < end_pos) begin
          rb = rd8(in_pos);
          in_pos++;
        end else st = ST_END;
      end
      OP_NEXT: begin
        if (cur_mode != MODE_PLAY) st = ST_MODE;
        else if (frm_now + 1 >= frm_total) st = ST_END;
        else begin
          frm_now++;
          if (rd16(hdr_pos + 2) == RepeatMark) hdr_pos += 4;
          else begin
            prev_pos = hdr_pos + 4;
            hdr_pos = end_pos;
          end
          cnt = rd16(hdr_pos + 2);
          if (cnt == RepeatMark) in_pos = prev_pos;
          else begin
            in_pos = hdr_pos + 4;
            end_pos = clamp_end(in_pos + cnt);
          end
          fic = rd16(hdr_pos);
        end
      end
      OP_START: begin
        if (cur_mode != MODE_END) st = ST_MODE;
        else if (used_sz + 4 > Depth) st = ST_FULL;
        else begin
          hdr_pos = used_sz;
          frm_now = frm_total;
          in_pos = hdr_pos + 4;
          if (hdr_pos == 0) cyc_start = t.start_cycles;
          cur_mode = MODE_REC;
        end
      end
      OP_STORE: begin
        if (cur_mode != MODE_REC) st = ST_MODE;
        else if (in_pos >= Depth || in_pos - (hdr_pos + 4) >= MaxFrameIn) st = ST_FULL;
        else begin
          wr8(in_pos, t.data_byte);
          in_pos++;
        end
      end
      OP_END_FRAME: begin
        if (cur_mode != MODE_REC) st = ST_MODE;
        else close_frame(t.instr_count);
      end
      OP_START_REC: begin
        if (cur_mode != MODE_PLAY) st = ST_MODE;
        else if (hdr_pos + 4 > Depth) st = ST_FULL;
        else begin
          if (prev_pos == 0) end_pos = 0;
          else if (end_pos <= hdr_pos) begin
            // repeated frame: its bytes get copied behind the new header
            n = in_pos - prev_pos;
            if (hdr_pos + 4 + n > Depth) st = ST_FULL;
            else begin
              for (int unsigned k = 0; k < n; k++) wr8(hdr_pos + 4 + k, rd8(prev_pos + k));
              in_pos = hdr_pos + 4 + n;
              end_pos = prev_pos + rd16(prev_pos - 2);
            end
          end else end_pos = prev_pos + rd16(prev_pos - 2);
          if (st == ST_OK) begin
            used_sz = hdr_pos;
            frm_total = frm_now;
            cur_mode = MODE_REC;
          end
        end
      end
      OP_AMEND: begin
        if (cur_mode != MODE_REC) st = ST_MODE;
        else if (hdr_pos < 4 || prev_pos < 4 || in_pos > hdr_pos + 4) close_frame(t.instr_count);
        else begin
          rep = (prev_pos + rd16(prev_pos - 2)) != hdr_pos;
          pf = rep ? hdr_pos - 4 : prev_pos - 4;
          sum = rd16(pf) + t.instr_count;
          wr16(pf, (sum > 16'hFFFF) ? 16'hFFFF : sum);
          cur_mode = MODE_END;
        end
      end
      default: ;
    endcase
    r.status             = st;
    r.read_byte          = rb[7:0];
    r.frame_instructions = fic[15:0];
    r.mode               = cur_mode;
    r.frames_total       = frm_total[14:0];
    r.frame_index        = frm_now[14:0];
    r.first_cycles       = cyc_start;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid && !out_stall) begin
      irfs_out_t e;
      if (result_q.size() == 0) begin
        $error("result with no transaction pending: %h", out_data);
        errors++;
      end else begin
        e = result_q.pop_front();
        if (out_data.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_data.status); errors++;
        end
        if (out_data.read_byte !== e.read_byte) begin
          $error("read_byte: expected %0d actual %0d", e.read_byte, out_data.read_byte);
          errors++;
        end
        if (out_data.frame_instructions !== e.frame_instructions) begin
          $error("frame_instructions: expected %0d actual %0d", e.frame_instructions,
                 out_data.frame_instructions);
          errors++;
        end
        if (out_data.mode !== e.mode) begin
          $error("mode: expected %0d actual %0d", e.mode, out_data.mode); errors++;
        end
        if (out_data.frames_total !== e.frames_total) begin
          $error("frames_total: expected %0d actual %0d", e.frames_total,
                 out_data.frames_total);
          errors++;
        end
        if (out_data.frame_index !== e.frame_index) begin
          $error("frame_index: expected %0d actual %0d", e.frame_index, out_data.frame_index);
          errors++;
        end
        if (out_data.first_cycles !== e.first_cycles) begin
          $error("first_cycles: expected %0d actual %0d", e.first_cycles,
                 out_data.first_cycles);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    if (cycles >= CycLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge with valid possibly still high
  task automatic send(op_e op, int unsigned b = 0, int unsigned ic = 0,
                      int unsigned cyc = 0);
    irfs_in_t t;
    t.operation = op; t.data_byte = b[7:0]; t.instr_count = ic[15:0];
    t.start_cycles = cyc;
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    result_q.push_back(frame_store_predict(t));
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
      @(negedge clk_i);
    end
  endtask

  task automatic send_raw(irfs_in_t t);
    send(op_e'(t.operation), t.data_byte, t.instr_count, t.start_cycles);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk_i);
    repeat (IdleWait) @(negedge clk_i);
  endtask

  task automatic write_limit(int unsigned v);
    drain();
    cfg_wdata <= v[15:0];
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    max_instr = v & 16'hFFFF;
  endtask

  task automatic load_frame(int unsigned ic, int unsigned cnt);
    send(OP_LOAD, ic & 8'hFF);
    send(OP_LOAD, ic >> 8);
    send(OP_LOAD, cnt & 8'hFF);
    send(OP_LOAD, cnt >> 8);
    if (cnt != RepeatMark) repeat (cnt) send(OP_LOAD, $urandom_range(255));
  endtask

  // the bottom of the store gets written once, then a short look at it
  task automatic test_load_and_purge();
    for (int unsigned i = 0; i < PrefillLen; i++) send(OP_LOAD, $urandom_range(255));
    send(OP_SCAN);
    send(OP_GET);
    send(OP_NEXT);
    send(OP_PURGE);
  endtask

  task automatic test_record_playback();
    send(OP_GET);
    send(OP_STORE, 8'h55);
    send(OP_REWIND);
    send(OP_START, 0, 0, 32'hFFFF_FFFF);
    send(OP_START);
    send(OP_STORE, 8'hFF);
    send(OP_STORE, 8'h00);
    send(OP_SCAN);
    send(OP_LOAD, 1);
    send(OP_END_FRAME, 0, 16'hFFFF);
    send(OP_START, 0, 0, 32'h1234);
    send(OP_END_FRAME, 0, 0);
    send(OP_REWIND);
    send(OP_GET);
    send(OP_GET);
    send(OP_GET);
    send(OP_NEXT);
    send(OP_GET);
    send(OP_NEXT);
    send(OP_START_REC);
    send(OP_AMEND, 0, 16'hFFFF);
    send(op_e'(4'd15), 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  // repeated frames, the scan fix of a leading one, copy on start recording
  task automatic test_repeat_and_amend();
    send(OP_PURGE);
    load_frame(9, RepeatMark);
    load_frame(5, 2);
    load_frame(7, RepeatMark);
    load_frame(3, 1);
    send(OP_SCAN);
    send(OP_NEXT);
    send(OP_GET);
    send(OP_NEXT);
    send(OP_GET);
    send(OP_START_REC);
    send(OP_STORE, 8'hA5);
    send(OP_END_FRAME, 0, 11);
    send(OP_START);
    send(OP_AMEND, 0, 16'hFFF0);
    send(OP_REWIND);
    send(OP_NEXT);
    send(OP_NEXT);
    send(OP_START_REC);
    send(OP_AMEND, 0, 4);
    write_limit(1);
    send(OP_SCAN);
    write_limit(65535);
    send(OP_SCAN);
    write_limit(DefMaxInstr);
  endtask

  task automatic random_session();
    int unsigned kind, k;
    irfs_in_t    t;
    if (used_sz > PurgeAt) send(OP_PURGE);
    kind = $urandom_range(99);
    if (kind < 35) begin
      if (cur_mode == MODE_PLAY && $urandom_range(1)) send(OP_START_REC);
      else begin
        if (cur_mode == MODE_REC) send(OP_END_FRAME, 0, $urandom_range(65535));
        send(OP_START, 0, 0, $urandom);
      end
      repeat ($urandom_range(5)) send(OP_STORE, $urandom_range(255));
      if ($urandom_range(1)) send(OP_AMEND, 0, $urandom);
      else send(OP_END_FRAME, 0, $urandom);
    end else if (kind < 65) begin
      send($urandom_range(3) ? OP_REWIND : OP_SCAN);
      repeat ($urandom_range(1, 8)) send($urandom_range(1) ? OP_GET : OP_NEXT);
    end else if (kind < 85) begin
      if (cur_mode == MODE_REC || $urandom_range(1)) send(OP_PURGE);
      k = $urandom_range(1, 4);
      repeat (k) begin
        load_frame($urandom_range(3) ? $urandom_range(400) : $urandom_range(65535),
                   ($urandom_range(4) == 0) ? RepeatMark : $urandom_range(3));
      end
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send(OP_LOAD, $urandom);
      send(OP_SCAN);
    end else begin
      t.operation    = 4'($urandom_range(15));
      t.data_byte    = 8'($urandom_range(255));
      t.instr_count  = 16'($urandom_range(65535));
      t.start_cycles = $urandom;
      send_raw(t);
    end
  endtask

  task automatic test_random_phases();
    int unsigned idle_tab [4] = '{0, 78, 0, 31};
    int unsigned stall_tab[4] = '{0, 0, 78, 31};
    int unsigned lim_tab  [4] = '{1, 65535, 300, 20000};
    for (int p = 0; p < 4; p++) begin
      write_limit((p == 2) ? $urandom_range(1, 65535) : lim_tab[p]);
      send_idle_pct = idle_tab[p];
      stall_pct     = stall_tab[p];
      repeat (10) random_session();
    end
    stall_pct = 0;
    send_idle_pct = 0;
  endtask

  initial begin
    clear_model();
    max_instr = DefMaxInstr;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_load_and_purge();
    test_record_playback();
    test_repeat_and_amend();
    test_random_phases();
    drain();
    if (errors == 0 && result_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
